// File: hdl/frkv_pkg.sv
package frkv_pkg;

  localparam int ENTRIES_DEFAULT = 4;
  localparam int OCC_W           = 3;

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;
    logic [OCC_W-1:0]   occupancy;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

// File: hdl/frkv_ctrl.sv
module frkv_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  frkv_pkg::sts_t sts,
  output frkv_pkg::cmd_t cmd
);
  import frkv_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_scan_follows_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_SCAN)
    else $error("scan did not follow request load");

  a_commit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> sts.out_free)
    else $error("commit while result register held");

  a_done_after_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && !$past(state == S_DONE) |-> $past(sts.scan_done))
    else $error("entered done without finished scan");
`endif

endmodule

// File: hdl/frkv_dpath.sv
module frkv_dpath #(
  parameter int ENTRIES = frkv_pkg::ENTRIES_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  frkv_pkg::req_t req,
  input  frkv_pkg::cmd_t cmd,
  output frkv_pkg::sts_t sts,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output frkv_pkg::rsp_t rsp
);
  import frkv_pkg::*;

  localparam int PW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int SW = $clog2(2 * ENTRIES);

  // storage, oldest entry at head
  logic signed [31:0] key_mem [ENTRIES];
  logic signed [31:0] val_mem [ENTRIES];
  logic signed [31:0] key_q;
  logic signed [31:0] val_q;

  logic [PW-1:0] head;
  logic [CW-1:0] count;

  req_t               req_q;
  logic [PW-1:0]      ptr;
  logic [CW-1:0]      iss;
  logic               rd_vld;
  logic [PW-1:0]      rd_addr;
  logic               first;
  logic               hit_f;
  logic [PW-1:0]      hit_slot;
  logic signed [31:0] hit_val;
  logic signed [31:0] old_key;

  logic               rd_issue;
  logic [PW-1:0]      ptr_inc;
  logic [PW-1:0]      head_inc;
  logic [SW-1:0]      tail_sum;
  logic [PW-1:0]      tail;
  logic               full;
  logic               is_put;
  logic               do_evict;
  logic               do_append;
  logic               wr_en;
  logic [PW-1:0]      wr_addr;
  logic [CW-1:0]      count_next;
  rsp_t               rsp_next;

  assign rd_issue = cmd.scan && (iss != count);
  assign ptr_inc  = (ptr == PW'(ENTRIES - 1)) ? '0 : ptr + 1'b1;
  assign head_inc = (head == PW'(ENTRIES - 1)) ? '0 : head + 1'b1;
  assign tail_sum = SW'(head) + SW'(count);
  assign tail     = (tail_sum >= SW'(ENTRIES)) ? PW'(tail_sum - SW'(ENTRIES)) : PW'(tail_sum);
  assign full     = (count == CW'(ENTRIES));

  assign is_put    = (req_q.kind == KIND_PUT);
  assign do_evict  = is_put && !hit_f && full;
  assign do_append = is_put && !hit_f && !full;
  assign wr_en     = cmd.commit && is_put;
  assign wr_addr   = hit_f ? hit_slot : tail;
  assign count_next = do_append ? count + 1'b1 : count;

  assign sts.scan_done = (iss == count) && !rd_vld;
  assign sts.out_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    rsp_next.hit         = hit_f;
    rsp_next.read_value  = (!is_put && hit_f) ? hit_val : '0;
    rsp_next.evicted     = do_evict;
    rsp_next.evicted_key = do_evict ? old_key : '0;
    rsp_next.occupancy   = OCC_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      key_q <= key_mem[ptr];
      val_q <= val_mem[ptr];
    end
    if (wr_en) begin
      key_mem[wr_addr] <= req_q.key;
      val_mem[wr_addr] <= req_q.value;
    end
  end

  // scan control and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      count  <= '0;
      iss    <= '0;
      rd_vld <= 1'b0;
      first  <= 1'b0;
      hit_f  <= 1'b0;
      ptr    <= '0;
    end else begin
      if (cmd.load) begin
        ptr    <= head;
        iss    <= '0;
        rd_vld <= 1'b0;
        first  <= 1'b1;
        hit_f  <= 1'b0;
      end else if (cmd.scan) begin
        rd_vld <= rd_issue;
        if (rd_issue) begin
          ptr <= ptr_inc;
          iss <= iss + 1'b1;
        end
        if (rd_vld) begin
          first <= 1'b0;
          if (key_q == req_q.key) begin
            hit_f <= 1'b1;
          end
        end
      end
      if (cmd.commit) begin
        count <= count_next;
        if (do_evict) begin
          head <= head_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
    if (rd_issue) begin
      rd_addr <= ptr;
    end
    if (cmd.scan && rd_vld) begin
      if (first) begin
        old_key <= key_q;
      end
      if (key_q == req_q.key) begin
        hit_slot <= rd_addr;
        hit_val  <= val_q;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ENTRIES))
    else $error("occupancy beyond capacity");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head <= PW'(ENTRIES - 1))
    else $error("head pointer out of range");

  a_count_only_on_commit: assert property (@(posedge clk) disable iff (rst)
    !cmd.commit |=> $stable(count) && $stable(head))
    else $error("store order changed outside commit");

  a_commit_presents: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> rsp_valid)
    else $error("committed result not presented");
`endif

endmodule

// File: hdl/fifo_replacement_kv_cache.sv
// Fully associative key/value store of ENTRIES entries with first-in-first-out
// replacement. Each request is a get (kind 0) or a put (kind 1) and yields exactly
// one result. A get reports hit and the stored value (zero on a miss). A put on a
// present key rewrites its value in place without touching the age order; a put on
// an absent key appends the entry as the youngest, first evicting the oldest one
// when full, whose key is then reported. Occupancy is the entry count after the
// request. A request is taken, then the keys, which live in a single-read-port
// memory, are swept one entry per cycle from the oldest; the registered read of
// the last entry is compared, the sweep end is seen, and the result is committed.
// On an empty store there is no read to wait for. The commit also waits for as
// long as the previous result sits stalled in the result register. Only one
// request is in flight; a finished result waits in its own register, so the next
// request is taken and swept while the previous result is still stalled.
module fifo_replacement_kv_cache #(
  parameter int ENTRIES = frkv_pkg::ENTRIES_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  // request channel
  input  logic           req_valid,
  output logic           req_stall,
  input  frkv_pkg::req_t req,
  // result channel
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output frkv_pkg::rsp_t rsp
);
  import frkv_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: idle -> sweep -> commit
  frkv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // entry memory, age pointers, key compare and result register
  frkv_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// File: verif/fifo_replacement_kv_cache_checker.sv
module fifo_replacement_kv_cache_checker #(
  parameter int ENTRIES = frkv_pkg::ENTRIES_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_stall,
  input  frkv_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  frkv_pkg::rsp_t rsp,
  output int             mismatches,
  output int             outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the store, oldest entry in slot 0
  logic [31:0] shadow_keys[ENTRIES];
  logic [31:0] shadow_vals[ENTRIES];
  int          shadow_fill;

  frkv_pkg::rsp_t awaited_results[$];
  int             errors = 0;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic frkv_pkg::rsp_t cache_access(frkv_pkg::req_t r);
    frkv_pkg::rsp_t o;
    int             slot;
    o    = '0;
    slot = -1;
    for (int i = 0; i < shadow_fill; i++) begin
      if (slot < 0 && shadow_keys[i] == r.key) slot = i;
    end
    o.hit = (slot >= 0);
    if (r.kind == frkv_pkg::KIND_GET) begin
      if (o.hit) o.read_value = shadow_vals[slot];
    end else if (o.hit) begin
      shadow_vals[slot] = r.value;
    end else begin
      if (shadow_fill == ENTRIES) begin
        o.evicted     = 1'b1;
        o.evicted_key = shadow_keys[0];
        for (int i = 0; i + 1 < ENTRIES; i++) begin
          shadow_keys[i] = shadow_keys[i + 1];
          shadow_vals[i] = shadow_vals[i + 1];
        end
        shadow_fill = ENTRIES - 1;
      end
      shadow_keys[shadow_fill] = r.key;
      shadow_vals[shadow_fill] = r.value;
      shadow_fill++;
    end
    o.occupancy = frkv_pkg::OCC_W'(shadow_fill);
    return o;
  endfunction

  task automatic field_check(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    frkv_pkg::rsp_t want;
    if (rst) begin
      shadow_fill = 0;
      awaited_results.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result: hit %0b read_value %0h", rsp.hit, rsp.read_value);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          field_check("hit", 32'(want.hit), 32'(rsp.hit));
          field_check("read_value", want.read_value, rsp.read_value);
          field_check("evicted", 32'(want.evicted), 32'(rsp.evicted));
          field_check("evicted_key", want.evicted_key, rsp.evicted_key);
          field_check("occupancy", 32'(want.occupancy), 32'(rsp.occupancy));
        end
      end
      if (req_valid && !req_stall) awaited_results.push_back(cache_access(req));
    end
    outstanding <= awaited_results.size();
    mismatches  <= errors;
  end

endmodule

// File: verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import frkv_pkg::*;

  localparam int DEPTH     = ENTRIES_DEFAULT;
  localparam int HOLD_LEN  = 300;   // long receiver hold-off, in cycles
  localparam int PHASES    = 8;
  localparam int PHASE_LEN = 250;   // random requests per phase

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b1;
  rsp_t rsp;

  int mismatches;
  int outstanding;

  // hold-off handshake between stimulus and the receiver process
  int holds_asked = 0;
  int holds_done  = 0;

  // keys drawn from a small pool so gets hit and puts collide
  logic [31:0] key_pool[6];
  bit          no_idle = 1'b0;

  fifo_replacement_kv_cache #(.ENTRIES(DEPTH)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  fifo_replacement_kv_cache_checker #(.ENTRIES(DEPTH)) i_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Run limit: worst case is roughly 2k requests, each with the longest sender gap,
  // its time in the block and the longest receiver stall, plus the hold-offs.
  // That is well under 3 ms, so 10 ms leaves plenty of margin.
  initial begin
    #10ms;
    $display("tb failed");
    $finish;
  end

  // Idle length: mostly none, often short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic req_t mk(logic kind, logic [31:0] key, logic [31:0] value);
    req_t r;
    r.kind  = kind;
    r.key   = key;
    r.value = value;
    return r;
  endfunction

  function automatic logic [31:0] edgy_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Drive one request and hold it until accepted. The gap is taken first,
  // with valid low, so valid is only ever written once per edge.
  task automatic send_request(input req_t r, input int gap);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // Sender pause: stop offering and wait for every result to come back.
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Receiver: random stall bursts separated by free stretches, with the odd
  // long free run, and a long hold-off whenever stimulus asks for one.
  initial begin
    int stall_len;
    int free_len;
    @(posedge clk);
    forever begin
      if (holds_asked != holds_done) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        holds_done++;
      end else begin
        stall_len = idle_len();
        free_len  = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 6);
        if (stall_len > 0) begin
          rsp_stall <= 1'b1;
          repeat (stall_len) @(posedge clk);
        end
        rsp_stall <= 1'b0;
        repeat (free_len) @(posedge clk);
      end
    end
  end

  initial begin
    logic [31:0] key;
    logic [31:0] value;
    int          gap;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: get on an empty store, fill with extreme keys and values,
    // a stored -1 read back as a value, update in place, then evictions.
    send_request(mk(KIND_GET, 32'h0000_0001, 32'hffff_ffff), 0);   // miss when empty
    send_request(mk(KIND_PUT, 32'h8000_0000, 32'h7fff_ffff), 0);
    send_request(mk(KIND_PUT, 32'h7fff_ffff, 32'h8000_0000), 1);
    send_request(mk(KIND_GET, 32'h8000_0000, 32'h0000_0000), 0);
    send_request(mk(KIND_GET, 32'h7fff_ffff, 32'h1234_5678), 0);
    send_request(mk(KIND_PUT, 32'hffff_ffff, 32'hffff_ffff), 2);
    send_request(mk(KIND_GET, 32'hffff_ffff, 32'h0000_0000), 0);   // -1 is a real value
    send_request(mk(KIND_PUT, 32'h0000_0000, 32'h0000_0000), 0);   // store now full
    send_request(mk(KIND_GET, 32'h0000_0000, 32'hdead_beef), 0);
    send_request(mk(KIND_GET, 32'h5555_aaaa, 32'h0000_0000), 0);   // miss when full
    send_request(mk(KIND_PUT, 32'h7fff_ffff, 32'haaaa_5555), 0);   // update, no eviction
    send_request(mk(KIND_GET, 32'h7fff_ffff, 32'h0000_0000), 0);
    send_request(mk(KIND_PUT, 32'h5555_aaaa, 32'h0f0f_0f0f), 0);   // evicts oldest
    send_request(mk(KIND_GET, 32'h8000_0000, 32'h0000_0000), 0);   // evicted key misses
    send_request(mk(KIND_GET, 32'h7fff_ffff, 32'h0000_0000), 0);   // order kept on update
    send_request(mk(KIND_PUT, 32'haaaa_5555, 32'hf0f0_f0f0), 5);   // evicts 7fffffff
    send_request(mk(KIND_PUT, 32'h8000_0000, 32'h8000_0000), 0);   // evicts ffffffff
    send_request(mk(KIND_GET, 32'h0000_0000, 32'h0000_0000), 0);
    send_request(mk(KIND_PUT, 32'h0000_0000, 32'hffff_ffff), 0);   // update of key zero
    send_request(mk(KIND_GET, 32'h0000_0000, 32'h0000_0000), 0);
    send_request(mk(KIND_GET, 32'haaaa_5555, 32'h0000_0000), 0);
    drain();

    // Random phases: a fresh key pool each phase, mostly pool keys with the
    // odd random key as noise; every other phase runs with no sender gaps.
    for (int p = 0; p < PHASES; p++) begin
      for (int i = 0; i < 6; i++) key_pool[i] = edgy_word();
      no_idle = (p % 2 == 1);
      if (p == 2 || p == 5) holds_asked++;   // block fills up behind the hold-off
      for (int n = 0; n < PHASE_LEN; n++) begin
        key   = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, 5)];
        value = edgy_word();
        gap   = no_idle ? 0 : idle_len();
        send_request(mk(($urandom_range(0, 1) == 1) ? KIND_PUT : KIND_GET, key, value), gap);
      end
      if (p == 3) drain();
    end

    drain();
    repeat (20) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/frkv_pkg.sv
hdl/frkv_ctrl.sv
hdl/frkv_dpath.sv
hdl/fifo_replacement_kv_cache.sv
verif/fifo_replacement_kv_cache_checker.sv
verif/tb.sv
